// File: hdl/fss_pkg.sv
// Shared types, constants and helpers for the fuzzy subsequence scorer.
// No dependencies; used by the front, the back, the top level and the bench.
package fss_pkg;

    localparam int unsigned PATTERN_MAX = 8;
    localparam int unsigned PAT_BYTES   = 8;

    localparam logic [6:0] SCORE_EMPTY     = 7'd100;
    localparam logic [6:0] SCORE_NONE      = 7'd0;
    localparam logic [6:0] BONUS_ADJACENT  = 7'd10;
    localparam logic [6:0] BONUS_FIRST_POS = 7'd5;
    localparam logic [6:0] BONUS_MATCH     = 7'd1;
    localparam logic [7:0] LEN_GAIN        = 8'd20;
    localparam logic [7:0] ASCII_MAX       = 8'h7f;

    localparam logic [0:0] CFG_PAT_CHARS = 1'b0;
    localparam logic [0:0] CFG_PAT_LEN   = 1'b1;

    // Per-record summary handed from the front to the back.
    typedef struct packed {
        logic        empty;   // pattern length zero
        logic        fail;    // non-ASCII seen or pattern not fully matched
        logic [6:0]  sum;
        logic [3:0]  plen;
        logic [15:0] index;
    } fss_rec_t;

    // Case fold of A..Z only.
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// File: hdl/fss_fifo.sv
// Small register queue between the front and the back of the scorer.
// Generic width and depth; no package dependency.
module fss_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/fss_front.sv
// Front of the scorer: takes one character per beat, runs the subsequence match
// and pushes a record summary at record end. Depends on fss_pkg.
module fss_front #(
    parameter int unsigned LW = 16,
    parameter int unsigned MAX_TEXT_LEN = 65535
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [20:0]        in_char,
    input  logic               in_last,
    input  logic [62:0]        pat_chars,
    input  logic [3:0]         pat_len,
    output logic               push,
    output fss_pkg::fss_rec_t  push_rec,
    output logic [LW-1:0]      push_tlen,
    input  logic               full
);

    logic [3:0]    matched_reg;
    logic [6:0]    sum_reg;
    logic [6:0]    prev_reg;
    logic [LW-1:0] tlen_reg;
    logic          non_ascii_reg;
    logic [15:0]   rec_cnt_reg;

    logic [3:0]    matched_next;
    logic [6:0]    sum_next;
    logic [6:0]    prev_next;
    logic [LW-1:0] tlen_next;
    logic          non_ascii_next;

    logic [3:0]  len;
    logic [63:0] pat64;
    logic [2:0]  cur_idx;
    logic [2:0]  ref_idx;
    logic [7:0]  cur_pb;
    logic [7:0]  ref_pb;
    logic [7:0]  lc;
    logic        is_ascii;
    logic        hit;
    logic        accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign len      = (pat_len > 4'(fss_pkg::PATTERN_MAX)) ? 4'(fss_pkg::PATTERN_MAX) : pat_len;
    assign pat64    = {1'b0, pat_chars};
    assign cur_idx  = matched_reg[2:0];
    assign ref_idx  = (matched_reg == '0) ? 3'd0 : 3'(matched_reg - 1'b1);
    assign cur_pb   = pat64[{cur_idx, 3'b000} +: 8];
    assign ref_pb   = pat64[{ref_idx, 3'b000} +: 8];
    assign lc       = fss_pkg::fold({1'b0, in_char[6:0]});
    assign is_ascii = (in_char <= 21'(fss_pkg::ASCII_MAX));
    assign hit      = is_ascii && (matched_reg < len) && (lc == fss_pkg::fold(cur_pb));

    always_comb
    begin
        matched_next   = matched_reg;
        sum_next       = sum_reg;
        non_ascii_next = non_ascii_reg || !is_ascii;
        prev_next      = lc[6:0];
        tlen_next      = (tlen_reg < LW'(MAX_TEXT_LEN)) ? tlen_reg + 1'b1 : tlen_reg;
        if (hit)
        begin
            sum_next = sum_reg + fss_pkg::BONUS_MATCH
                     + (((tlen_reg != '0) && ({1'b0, prev_reg} == fss_pkg::fold(ref_pb)))
                        ? fss_pkg::BONUS_ADJACENT : 7'd0)
                     + ((tlen_reg == '0) ? fss_pkg::BONUS_FIRST_POS : 7'd0);
            matched_next = matched_reg + 1'b1;
        end
    end

    assign push           = accept && in_last;
    assign push_rec.empty = (len == '0);
    assign push_rec.fail  = non_ascii_next || (matched_next < len);
    assign push_rec.sum   = sum_next;
    assign push_rec.plen  = len;
    assign push_rec.index = rec_cnt_reg;
    assign push_tlen      = tlen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg   <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            tlen_reg      <= '0;
            non_ascii_reg <= 1'b0;
            rec_cnt_reg   <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                matched_reg   <= '0;
                sum_reg       <= '0;
                prev_reg      <= '0;
                tlen_reg      <= '0;
                non_ascii_reg <= 1'b0;
                rec_cnt_reg   <= rec_cnt_reg + 1'b1;
            end
            else
            begin
                matched_reg   <= matched_next;
                sum_reg       <= sum_next;
                prev_reg      <= prev_next;
                tlen_reg      <= tlen_next;
                non_ascii_reg <= non_ascii_next;
            end
        end
    end

endmodule

// File: hdl/fss_back.sv
// Back of the scorer: pops record summaries, adds the length term through a
// bit-serial divider and holds the result beat. Depends on fss_pkg.
module fss_back #(
    parameter int unsigned LW = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_valid,
    output logic              rec_pop,
    input  fss_pkg::fss_rec_t rec,
    input  logic [LW-1:0]     rec_tlen,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [22:0]       out_data
);

    localparam int unsigned CW = (LW > 9) ? LW : 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t        state_reg;
    logic [7:0]    num_reg;
    logic [7:0]    rem_reg;
    logic [7:0]    quo_reg;
    logic [2:0]    step_reg;
    logic [LW-1:0] div_reg;
    logic [6:0]    sum_reg;
    logic [6:0]    res_reg;
    logic [15:0]   idx_reg;
    logic          out_valid_reg;
    logic [22:0]   out_data_reg;

    logic [8:0]    trial;
    logic          take;
    logic [7:0]    quo_next;

    assign rec_pop   = (state_reg == ST_IDLE) && rec_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign trial     = {rem_reg, num_reg[7]};
    assign take      = (CW'(trial) >= CW'(div_reg));
    assign quo_next  = {quo_reg[6:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            div_reg       <= '0;
            sum_reg       <= '0;
            res_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // in ST_DONE the output register is reloaded below instead
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rec_valid)
                    begin
                        idx_reg <= rec.index;
                        sum_reg <= rec.sum;
                        if (rec.empty)
                        begin
                            res_reg   <= fss_pkg::SCORE_EMPTY;
                            state_reg <= ST_DONE;
                        end
                        else if (rec.fail)
                        begin
                            res_reg   <= fss_pkg::SCORE_NONE;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            num_reg   <= 8'(rec.plen) * fss_pkg::LEN_GAIN;
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            step_reg  <= '0;
                            div_reg   <= (rec_tlen == '0) ? LW'(1) : rec_tlen;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    // one quotient bit per cycle, restoring
                    rem_reg  <= take ? 8'(CW'(trial) - CW'(div_reg)) : trial[7:0];
                    num_reg  <= {num_reg[6:0], 1'b0};
                    quo_reg  <= quo_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd7)
                    begin
                        res_reg   <= sum_reg + quo_next[6:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {idx_reg, res_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/fuzzy_subsequence_scorer.sv
// Flow: on the tlast beat the front pushes a record summary into the queue; the back
// pops it, runs the divider for matched records only and then loads the result beat.
// Throughput: one character per cycle while the queue is not full; the back spends
// longer on a matched record than on a failed or empty-pattern one (8-step serial
// divider); a two-record queue absorbs bursts of short records.
// Reset: rst_n clears all control state, the pattern registers and the record counter.
module fuzzy_subsequence_scorer #(
    parameter int unsigned MAX_TEXT_LEN = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] character, [23:21] zero
    input  logic        s_axis_tlast,   // is_last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [6:0] score, [22:7] record_index, [23] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [62:0] cfg_data
);

    localparam int unsigned LW = (MAX_TEXT_LEN > 1) ? $clog2(MAX_TEXT_LEN + 1) : 1;
    localparam int unsigned QW = LW + $bits(fss_pkg::fss_rec_t);

    logic [62:0] pat_chars_reg;
    logic [3:0]  pat_len_reg;

    logic              push;
    fss_pkg::fss_rec_t push_rec;
    logic [LW-1:0]     push_tlen;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [QW-1:0]     q_head;
    fss_pkg::fss_rec_t head_rec;
    logic [LW-1:0]     head_tlen;
    logic [22:0]       out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_chars_reg <= '0;
            pat_len_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fss_pkg::CFG_PAT_CHARS: pat_chars_reg <= cfg_data;
                fss_pkg::CFG_PAT_LEN:   pat_len_reg   <= cfg_data[3:0];
                default:                pat_len_reg   <= pat_len_reg;
            endcase
        end
    end

    fss_front #(
        .LW           (LW),
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata[20:0]),
        .in_last   (s_axis_tlast),
        .pat_chars (pat_chars_reg),
        .pat_len   (pat_len_reg),
        .push      (push),
        .push_rec  (push_rec),
        .push_tlen (push_tlen),
        .full      (q_full)
    );

    fss_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_tlen, push_rec}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    assign head_rec  = q_head[$bits(fss_pkg::fss_rec_t)-1:0];
    assign head_tlen = q_head[QW-1:$bits(fss_pkg::fss_rec_t)];

    fss_back #(
        .LW (LW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_valid),
        .rec_pop   (q_pop),
        .rec       (head_rec),
        .rec_tlen  (head_tlen),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {1'b0, out_data};

endmodule

// File: hdl/fss_checker.sv
// Port-level checks for the fuzzy subsequence scorer, bound to the top level.
// Depends only on the top-level port list.
module fss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic [15:0] last_idx_reg;
    logic        seen_reg;
    logic        out_beat;

    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg <= '0;
            seen_reg     <= 1'b0;
        end
        else if (out_beat)
        begin
            last_idx_reg <= m_axis_tdata[22:7];
            seen_reg     <= 1'b1;
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && !seen_reg |-> m_axis_tdata[22:7] == 16'd0)
        else $error("first record index after reset is not zero");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && seen_reg |-> m_axis_tdata[22:7] == last_idx_reg + 16'd1)
        else $error("record index skipped or repeated");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[23])
        else $error("tdata pad bit set");

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/fuzzy_subsequence_scorer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fuzzy_subsequence_scorer: a directed table, then random
// records, scored by an in-bench model or, for some directed rows, by a score given up front.
// Depends on fss_pkg and the fuzzy_subsequence_scorer RTL.
module fuzzy_subsequence_scorer_tb;

    localparam int unsigned TEXT_LEN_CAP  = 65535;
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned HOLD_AT_BEAT  = 60;
    localparam int unsigned RANDOM_ITEMS  = 1000;
    localparam int unsigned SCRIPT_ROWS   = 32;

    typedef struct packed {
        logic [6:0]  score;
        logic [15:0] index;
    } score_beat_t;

    typedef enum logic {ROW_REG, ROW_CHAR} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [0:0]  reg_idx;
        logic [62:0] value;     // register data, or the character in [20:0]
        logic        is_last;
        logic        typed;     // score below is known up front
        logic [6:0]  score;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;     // [20:0] character, [23:21] zero
    logic        s_axis_tlast;     // is_last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [6:0] score, [22:7] record_index, [23] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [62:0] cfg_data;

    fuzzy_subsequence_scorer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Matcher model: registers and per-record state
    logic [62:0]   pat_chars_m;
    logic [3:0]    pat_len_m;
    logic [3:0]    hits;
    logic [6:0]    run_sum;
    logic [7:0]    lc_prev;
    logic [15:0]   char_count;
    logic          saw_wide;
    logic [15:0]   rec_num;

    score_beat_t   pending_scores[$];
    int unsigned   errors;
    int unsigned   items_sent;
    int unsigned   beats_seen;
    int unsigned   cycles;
    logic          src_quiet;
    logic          snk_quiet;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] ascii_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pattern_byte(input int unsigned k);
        logic [63:0] wide;
        wide = {1'b0, pat_chars_m};
        return wide[8*k +: 8];
    endfunction

    function automatic int unsigned live_len();
        return (pat_len_m > fss_pkg::PATTERN_MAX) ? fss_pkg::PATTERN_MAX : pat_len_m;
    endfunction

    // Advances the matcher by one character; returns 1 with the score at record end.
    function automatic logic match_char(input logic [20:0] ch, input logic is_last,
                                        output score_beat_t res);
        int unsigned plen;
        int unsigned ref_k;
        int unsigned total;
        logic [7:0]  lc;
        plen = live_len();
        res = '0;
        lc = ascii_lower({1'b0, ch[6:0]});
        if (ch > 21'h7f)
        begin
            saw_wide = 1'b1;
        end
        else if (hits < plen)
        begin
            if (lc == ascii_lower(pattern_byte(hits)))
            begin
                // first match compares against the first pattern char itself
                ref_k = (hits == 0) ? 0 : hits - 1;
                if (char_count > 0 && lc_prev == ascii_lower(pattern_byte(ref_k)))
                begin
                    run_sum = run_sum + fss_pkg::BONUS_ADJACENT;
                end
                if (char_count == 0)
                begin
                    run_sum = run_sum + fss_pkg::BONUS_FIRST_POS;
                end
                run_sum = run_sum + fss_pkg::BONUS_MATCH;
                hits = hits + 4'd1;
            end
        end
        lc_prev = lc;
        if (char_count < TEXT_LEN_CAP)
        begin
            char_count = char_count + 16'd1;
        end
        if (!is_last)
        begin
            return 1'b0;
        end
        if (plen == 0)
        begin
            res.score = fss_pkg::SCORE_EMPTY;
        end
        else if (saw_wide || hits < plen)
        begin
            res.score = fss_pkg::SCORE_NONE;
        end
        else
        begin
            total = run_sum + (fss_pkg::LEN_GAIN * plen) / char_count;
            res.score = total[6:0];
        end
        res.index = rec_num;
        rec_num = rec_num + 16'd1;
        hits = '0;
        run_sum = '0;
        lc_prev = '0;
        char_count = '0;
        saw_wide = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_char(input logic [20:0] ch, input logic is_last,
                             input logic typed, input logic [6:0] typed_score);
        int unsigned gap;
        score_beat_t res;
        gap = src_quiet ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ch};
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (match_char(ch, is_last, res))
        begin
            if (typed)
            begin
                res.score = typed_score;
            end
            pending_scores.push_back(res);
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [62:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == fss_pkg::CFG_PAT_CHARS)
        begin
            pat_chars_m = value;
        end
        else
        begin
            pat_len_m = value[3:0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, drain all expected scores, then let the back end go quiet.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] small_letter();
        logic [7:0] b;
        b = 8'h61 + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1)
        begin
            b = b ^ 8'h20;
        end
        return b;
    endfunction

    task automatic random_config();
        logic [63:0] chars;
        logic [63:0] len_word;
        logic [3:0]  plen;
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            plen = 4'd0;
        end
        else if (pick == 1)
        begin
            plen = 4'($urandom_range(9, 15));
        end
        else
        begin
            plen = 4'($urandom_range(1, 8));
        end
        chars = {$urandom, $urandom};
        if ($urandom_range(0, 7) != 0)
        begin
            for (k = 0; k < fss_pkg::PAT_BYTES; k++)
            begin
                pick = $urandom_range(0, 11);
                if (pick < 8)
                begin
                    chars[8*k +: 8] = small_letter();
                end
                else if (pick < 11)
                begin
                    chars[8*k +: 8] = 8'($urandom_range(1, 127));
                end
                else
                begin
                    chars[8*k +: 8] = 8'($urandom_range(128, 255));
                end
            end
        end
        len_word = {$urandom, $urandom};
        len_word[3:0] = plen;
        if ($urandom_range(0, 1) == 1)
        begin
            write_reg(fss_pkg::CFG_PAT_CHARS, chars[62:0]);
            write_reg(fss_pkg::CFG_PAT_LEN, len_word[62:0]);
        end
        else
        begin
            write_reg(fss_pkg::CFG_PAT_LEN, len_word[62:0]);
            write_reg(fss_pkg::CFG_PAT_CHARS, chars[62:0]);
        end
    endtask

    // Mostly records that walk the pattern in order with filler between;
    // some noise records and stray non-ASCII characters.
    task automatic random_record();
        int unsigned plen;
        int unsigned n;
        int unsigned k;
        int unsigned next;
        logic [7:0]  pb;
        logic [20:0] ch;
        logic        noisy;
        plen = live_len();
        noisy = ($urandom_range(0, 9) == 0);
        n = noisy ? $urandom_range(1, 30) : plen + $urandom_range(0, 5);
        if (n == 0)
        begin
            n = 1;
        end
        next = 0;
        for (k = 0; k < n; k++)
        begin
            pb = 8'h00;
            if (!noisy && next < plen && $urandom_range(0, 9) < 6)
            begin
                pb = pattern_byte(next);
                next++;
                if ((pb | 8'h20) >= 8'h61 && (pb | 8'h20) <= 8'h7a && $urandom_range(0, 1) == 1)
                begin
                    pb = pb ^ 8'h20;
                end
            end
            if (pb != 8'h00)
            begin
                ch = {13'd0, pb};
            end
            else if (noisy && $urandom_range(0, 1) == 1)
            begin
                ch = 21'($urandom_range(1, 21'h10ffff));
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                ch = 21'($urandom_range(128, 21'h10ffff));
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                ch = {13'd0, small_letter()};
            end
            else
            begin
                ch = 21'($urandom_range(1, 127));
            end
            send_char(ch, k == n - 1, 1'b0, 7'd0);
        end
    endtask

    function automatic script_row_t reg_row(input logic [0:0] idx, input logic [62:0] value);
        script_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.value = value;
        return r;
    endfunction

    function automatic script_row_t chr_row(input logic [20:0] ch, input logic is_last);
        script_row_t r;
        r = '0;
        r.kind = ROW_CHAR;
        r.value = {42'd0, ch};
        r.is_last = is_last;
        return r;
    endfunction

    function automatic script_row_t end_row(input logic [20:0] ch, input logic [6:0] score);
        script_row_t r;
        r = chr_row(ch, 1'b1);
        r.typed = 1'b1;
        r.score = score;
        return r;
    endfunction

    initial
    begin : result_sink
        int unsigned stall;
        logic        hold_done;
        score_beat_t want;
        m_axis_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = snk_quiet ? 0 : $urandom_range(0, 4);
            // one long hold-off while the source is offering, so the block backs up
            if (!hold_done && beats_seen >= HOLD_AT_BEAT && s_axis_tvalid)
            begin
                stall = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            beats_seen++;
            if (pending_scores.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, score %0d index %0d",
                         $time, m_axis_tdata[6:0], m_axis_tdata[22:7]);
            end
            else
            begin
                want = pending_scores.pop_front();
                if (m_axis_tdata[6:0] !== want.score)
                begin
                    errors++;
                    $display("%0t: score mismatch, expected %0d, actual %0d",
                             $time, want.score, m_axis_tdata[6:0]);
                end
                if (m_axis_tdata[22:7] !== want.index)
                begin
                    errors++;
                    $display("%0t: record_index mismatch, expected %0d, actual %0d",
                             $time, want.index, m_axis_tdata[22:7]);
                end
            end
        end
    end

    initial
    begin : stimulus
        script_row_t script [0:SCRIPT_ROWS-1];
        int unsigned r;
        int unsigned phase_end;
        logic        chars_since_cfg;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = fss_pkg::CFG_PAT_CHARS;
        cfg_data      = '0;
        pat_chars_m   = '0;
        pat_len_m     = '0;
        hits          = '0;
        run_sum       = '0;
        lc_prev       = '0;
        char_count    = '0;
        saw_wide      = 1'b0;
        rec_num       = '0;
        items_sent    = 0;
        src_quiet     = 1'b0;
        snk_quiet     = 1'b0;
        chars_since_cfg = 1'b0;

        script = '{
            // reset state is the empty pattern, non-ASCII included
            end_row(21'h78, fss_pkg::SCORE_EMPTY),
            end_row(21'h10ffff, fss_pkg::SCORE_EMPTY),
            reg_row(fss_pkg::CFG_PAT_CHARS, 63'h63_4261),     // "aBc"
            reg_row(fss_pkg::CFG_PAT_LEN, 63'd3),
            chr_row(21'h41, 1'b0),                   // "ABC": first-position and adjacency
            chr_row(21'h42, 1'b0),
            chr_row(21'h43, 1'b1),
            chr_row(21'h61, 1'b0),                   // full match spoiled by non-ASCII
            chr_row(21'h62, 1'b0),
            chr_row(21'h63, 1'b0),
            end_row(21'h80, fss_pkg::SCORE_NONE),
            chr_row(21'h61, 1'b0),                   // partial match
            end_row(21'h78, fss_pkg::SCORE_NONE),
            chr_row(21'h51, 1'b0),                   // scattered match
            chr_row(21'h61, 1'b0),
            chr_row(21'h5a, 1'b0),
            chr_row(21'h62, 1'b0),
            chr_row(21'h63, 1'b1),
            reg_row(fss_pkg::CFG_PAT_CHARS, 63'h6867_6665_6463_6261),
            reg_row(fss_pkg::CFG_PAT_LEN, 63'd15),   // oversized length clamps to 8
            chr_row(21'h61, 1'b0),
            chr_row(21'h62, 1'b0),
            chr_row(21'h63, 1'b0),
            chr_row(21'h64, 1'b0),
            chr_row(21'h65, 1'b0),
            chr_row(21'h66, 1'b0),
            chr_row(21'h67, 1'b0),
            chr_row(21'h68, 1'b1),
            reg_row(fss_pkg::CFG_PAT_CHARS, 63'h7fff_ffff_ffff_ffff),
            reg_row(fss_pkg::CFG_PAT_LEN, 63'd1),    // pattern byte above 0x7f never matches
            end_row(21'h41, fss_pkg::SCORE_NONE),
            chr_row(21'h01, 1'b1)
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < SCRIPT_ROWS; r++)
        begin
            if (script[r].kind == ROW_REG)
            begin
                if (chars_since_cfg)
                begin
                    settle();
                end
                write_reg(script[r].reg_idx, script[r].value);
                chars_since_cfg = 1'b0;
            end
            else
            begin
                send_char(script[r].value[20:0], script[r].is_last,
                          script[r].typed, script[r].score);
                chars_since_cfg = 1'b1;
            end
        end
        settle();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            src_quiet = ($urandom_range(0, 3) == 0);
            snk_quiet = ($urandom_range(0, 3) == 0);
            random_config();
            phase_end = items_sent + $urandom_range(60, 140);
            while (items_sent < phase_end)
            begin
                random_record();
            end
            settle();
        end

        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/fss_pkg.sv
hdl/fss_fifo.sv
hdl/fss_front.sv
hdl/fss_back.sv
hdl/fuzzy_subsequence_scorer.sv
hdl/fss_checker.sv
dv/fuzzy_subsequence_scorer_tb.sv
